@@ design/assert_macros.svh @@
// Assertion macros used by the sound unit core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FCSU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fcsu_pkg.sv @@
package fcsu_pkg;

  // Timing constants.
  localparam int unsigned CPU_FREQ     = 4194304;
  localparam int unsigned FRAME_CYCLES = 8192;
  localparam int unsigned WAVE_BYTES   = 16;
  localparam int unsigned MAX_TICK     = 64;

  // Derived widths.
  localparam int unsigned CYC_W   = $clog2(MAX_TICK + 1);
  localparam int unsigned ACC_W   = $clog2(CPU_FREQ + MAX_TICK * 65536) + 1;
  localparam int unsigned FCC_W   = $clog2(FRAME_CYCLES + MAX_TICK);
  localparam int unsigned WAVE_AW = $clog2(WAVE_BYTES);
  localparam int unsigned PCD_W   = 24;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration registers.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SCALE = 1'd1;
  localparam logic [15:0] RATE_RESET  = 16'd48000;
  localparam logic [6:0]  SCALE_RESET = 7'd16;

  // Register addresses.
  localparam logic [7:0] A_NR10 = 8'h10;
  localparam logic [7:0] A_NR11 = 8'h11;
  localparam logic [7:0] A_NR12 = 8'h12;
  localparam logic [7:0] A_NR13 = 8'h13;
  localparam logic [7:0] A_NR14 = 8'h14;
  localparam logic [7:0] A_NR21 = 8'h16;
  localparam logic [7:0] A_NR22 = 8'h17;
  localparam logic [7:0] A_NR23 = 8'h18;
  localparam logic [7:0] A_NR24 = 8'h19;
  localparam logic [7:0] A_NR30 = 8'h1A;
  localparam logic [7:0] A_NR31 = 8'h1B;
  localparam logic [7:0] A_NR32 = 8'h1C;
  localparam logic [7:0] A_NR33 = 8'h1D;
  localparam logic [7:0] A_NR34 = 8'h1E;
  localparam logic [7:0] A_NR41 = 8'h20;
  localparam logic [7:0] A_NR42 = 8'h21;
  localparam logic [7:0] A_NR43 = 8'h22;
  localparam logic [7:0] A_NR44 = 8'h23;
  localparam logic [7:0] A_NR50 = 8'h24;
  localparam logic [7:0] A_NR51 = 8'h25;
  localparam logic [7:0] A_NR52 = 8'h26;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WAVE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_READ,
    OP_WAVE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       addr;
    logic [7:0]       data;
    logic [CYC_W-1:0] cyc;
  } q_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

  typedef struct packed {
    logic [3:0] init_vol;
    logic       add;
    logic [2:0] pace;
    logic [3:0] cur_vol;
    logic [2:0] count;
  } env_t;

  typedef struct packed {
    logic [2:0]  pace;
    logic        negate;
    logic [2:0]  shift;
    logic [10:0] shadow;
    logic [3:0]  count;
    logic        enabled;
  } sweep_t;

  typedef struct packed {
    logic [2:0] div;
    logic       narrow;
    logic [3:0] shift;
  } noise_t;

  // Square duty patterns, one bit per phase.
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] ph);
    logic [7:0] w;
    unique case (sel)
      2'd0: w = 8'b00000001;
      2'd1: w = 8'b00000011;
      2'd2: w = 8'b00001111;
      default: w = 8'b11111100;
    endcase
    return w[ph];
  endfunction

  // Wave output level as a right shift of the nibble.
  function automatic logic [2:0] level_shift(input logic [1:0] lvl);
    logic [2:0] s;
    unique case (lvl)
      2'd0: s = 3'd4;
      2'd1: s = 3'd0;
      2'd2: s = 3'd1;
      default: s = 3'd2;
    endcase
    return s;
  endfunction

endpackage

@@ design/fcsu_if.sv @@
// Input item channel.
interface fcsu_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic [6:0] tick_cycles;

  modport source (output valid, command, reg_addr, write_data, tick_cycles, input ready);
  modport sink (input valid, command, reg_addr, write_data, tick_cycles, output ready);
endinterface

// Result item channel.
interface fcsu_result_if;
  logic               valid;
  logic               ready;
  logic               is_sample;
  logic [7:0]         read_data;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, is_sample, read_data, left_sample, right_sample, input ready);
  modport sink (input valid, is_sample, read_data, left_sample, right_sample, output ready);
endinterface

@@ design/four_channel_sound_unit_core.sv @@
// Four-voice sound unit: two square voices (the first with a frequency sweep), a 32-nibble
// wave voice and a noise voice behind byte registers. Items enter a two-entry queue and are
// carried out one at a time by the execution sequencer. A register write, wave store write or
// register read is done as the item is taken; a read reply lands in the output register. A tick
// runs the advance, mix, scale and emit states; advance repeats while any running voice has an
// expired timer (one reload per voice per cycle, up to 32 for the wave voice at its highest
// pitch, typically far fewer), and emit may wait for the output register to be taken.
// Configuration writes (sample rate, sample scale) take effect when registered, even mid-tick.
`include "assert_macros.svh"

module four_channel_sound_unit_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fcsu_item_if.sink                        item_i,
  fcsu_result_if.source                    result_o,
  input  logic                             cfg_we_i,
  input  logic [fcsu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fcsu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import fcsu_pkg::*;

  q_item_t      q_item;
  logic         q_valid, q_ready;
  cfg_wr_t      cfg;
  back_status_t st;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_wdata_i;

  // Front end: classification and queue.
  fcsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready)
  );

  // Back end: execution sequencer and output register.
  fcsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .cfg_i     (cfg),
    .result_o  (result_o),
    .status_o  (st)
  );

  `FCSU_ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, q_valid && q_ready, st.idle, "queue popped while busy")
  `FCSU_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, q_valid && q_ready && (q_item.op == OP_TICK), !st.idle, "tick did not start")
  `FCSU_ASSERT_IMPL(a_sample_rd0, clk_i, rst_ni, result_o.valid && result_o.is_sample, result_o.read_data == 8'd0, "sample carries read data")
  `FCSU_ASSERT_IMPL(a_reply_zero, clk_i, rst_ni, result_o.valid && !result_o.is_sample, (result_o.left_sample == 16'sd0) && (result_o.right_sample == 16'sd0), "reply carries samples")

endmodule

@@ design/fcsu_front.sv @@
module fcsu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  fcsu_item_if.sink         item_i,
  output fcsu_pkg::q_item_t q_item_o,
  output logic              q_valid_o,
  input  logic              q_ready_i
);
  import fcsu_pkg::*;

  q_item_t           fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  q_item_t           entry;
  logic              keep, push, pop;

  // Classify the incoming item and clamp the tick length.
  always_comb begin
    entry.addr = item_i.reg_addr;
    entry.data = item_i.write_data;
    entry.cyc  = (item_i.tick_cycles > 7'(MAX_TICK)) ? CYC_W'(MAX_TICK)
                                                     : CYC_W'(item_i.tick_cycles);
    unique case (cmd_e'(item_i.command))
      CMD_TICK:  entry.op = OP_TICK;
      CMD_WRITE: entry.op = OP_WRITE;
      CMD_READ:  entry.op = OP_READ;
      default:   entry.op = OP_WAVE;
    endcase
    // Wave writes beyond the store are dropped here.
    keep = !((entry.op == OP_WAVE) && (item_i.reg_addr >= 8'(WAVE_BYTES)));
  end

  assign item_i.ready = (cnt_q != QCNT_W'(QDEPTH));
  assign push         = item_i.valid && item_i.ready && keep;
  assign q_valid_o    = (cnt_q != '0);
  assign pop          = q_valid_o && q_ready_i;
  assign q_item_o     = fifo_q[rptr_q];

  // Payload storage of the queue.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

@@ design/fcsu_back.sv @@
module fcsu_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fcsu_pkg::q_item_t      q_item_i,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  fcsu_pkg::cfg_wr_t      cfg_i,
  fcsu_result_if.source          result_o,
  output fcsu_pkg::back_status_t status_o
);
  import fcsu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_MIX,
    ST_SCALE,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration.
  logic [15:0] rate_q;
  logic [6:0]  scale_q;

  // Unit state.
  logic             power_q;
  logic [7:0]       pan_q, mvol_q;
  logic [ACC_W-1:0] acc_q;
  logic [FCC_W-1:0] fcc_q;
  logic [2:0]       fstep_q;
  logic [3:0]       von_q, dac_q, lon_q;
  logic [7:0]       lload_q [4];
  logic [8:0]       lleft_q [4];
  logic [10:0]      tp_q [3];
  logic [PCD_W-1:0] pcd_q [4];
  logic [1:0]       duty_q [2];
  logic [2:0]       dph_q [2];
  env_t             env_q [3];
  sweep_t           swp_q;
  logic [WAVE_AW:0] wph_q;
  logic [1:0]       wlvl_q;
  logic [7:0]       wave_q [WAVE_BYTES];
  noise_t           noise_q;
  logic [14:0]      nsh_q;

  // Tick working registers.
  logic [CYC_W-1:0] cyc_q;
  logic             emit_q;
  logic [5:0]       lsum_q, rsum_q;
  logic [9:0]       lm_q, rm_q;

  // Output register.
  logic               out_valid_q;
  logic               out_is_sample_q;
  logic [7:0]         out_rdata_q;
  logic signed [15:0] out_left_q, out_right_q;

  logic             out_free;
  logic             sq_v;
  logic [1:0]       sq_idx;
  logic [10:0]      sq_tp_new;
  logic [10:0]      wv_tp_new;
  logic [11:0]      inv [3];
  logic [PCD_W-1:0] sq_per [2];
  logic [PCD_W-1:0] wv_per, nz_per, sq_trig_per;
  logic [7:0]       nz_base;
  logic [14:0]      nz_next;
  logic             nz_fb;
  logic [3:0]       due;
  logic             adv_busy;
  logic [3:0]       lvl [4];
  logic [7:0]       wbyte;
  logic [3:0]       wnib;
  logic [5:0]       lsum, rsum;
  logic [ACC_W-1:0] acc_sum, acc_sub;
  logic [FCC_W-1:0] fcc_sum;
  logic             fr_tick;
  logic [10:0]      sw_delta;
  logic [11:0]      sw_nf;
  logic [7:0]       rd_data;
  logic [15:0]      left_prod, right_prod;

  assign out_free          = !out_valid_q || result_o.ready;
  assign q_ready_o         = (state_q == ST_IDLE) && out_free;
  assign status_o.idle     = (state_q == ST_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.is_sample    = out_is_sample_q;
  assign result_o.read_data    = out_rdata_q;
  assign result_o.left_sample  = out_left_q;
  assign result_o.right_sample = out_right_q;

  // Timer periods, trigger values and the noise shift step.
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      inv[v] = 12'd2048 - {1'b0, tp_q[v]};
    end
    sq_per[0] = PCD_W'({inv[0], 2'b00});
    sq_per[1] = PCD_W'({inv[1], 2'b00});
    wv_per    = PCD_W'({inv[2], 1'b0});
    nz_base   = (noise_q.div == 3'd0) ? 8'd8 : {1'b0, noise_q.div, 4'b0000};
    nz_per    = PCD_W'(nz_base) << noise_q.shift;
    nz_fb     = nsh_q[0] ^ nsh_q[1];
    nz_next   = {nz_fb, nsh_q[14:1]};
    if (noise_q.narrow) begin
      nz_next[6] = nz_fb;
    end
    sq_v        = (q_item_i.addr == A_NR24);
    sq_idx      = {1'b0, sq_v};
    sq_tp_new   = {q_item_i.data[2:0], tp_q[sq_idx][7:0]};
    sq_trig_per = PCD_W'({12'd2048 - {1'b0, sq_tp_new}, 2'b00});
    wv_tp_new   = {q_item_i.data[2:0], tp_q[2][7:0]};
    for (int v = 0; v < 4; v++) begin
      due[v] = von_q[v] && (pcd_q[v][PCD_W-1] || (pcd_q[v] == '0));
    end
    adv_busy = |due;
  end

  // Voice levels and the panned sums.
  always_comb begin
    lvl[0] = (von_q[0] && dac_q[0] && duty_bit(duty_q[0], dph_q[0])) ? env_q[0].cur_vol : 4'd0;
    lvl[1] = (von_q[1] && dac_q[1] && duty_bit(duty_q[1], dph_q[1])) ? env_q[1].cur_vol : 4'd0;
    wbyte  = wave_q[wph_q[WAVE_AW:1]];
    wnib   = wph_q[0] ? wbyte[3:0] : wbyte[7:4];
    lvl[2] = (von_q[2] && dac_q[2]) ? (wnib >> level_shift(wlvl_q)) : 4'd0;
    lvl[3] = (von_q[3] && dac_q[3] && !nsh_q[0]) ? env_q[2].cur_vol : 4'd0;
    lsum = '0;
    rsum = '0;
    for (int v = 0; v < 4; v++) begin
      if (pan_q[4 + v]) begin
        lsum = lsum + 6'(lvl[v]);
      end
      if (pan_q[v]) begin
        rsum = rsum + 6'(lvl[v]);
      end
    end
  end

  // Sample accumulator, frame counter, sweep arithmetic and output scaling.
  always_comb begin
    acc_sum    = acc_q + ACC_W'(cyc_q * rate_q);
    acc_sub    = acc_sum - ACC_W'(CPU_FREQ);
    fcc_sum    = fcc_q + FCC_W'(cyc_q);
    fr_tick    = power_q && (fcc_sum >= FCC_W'(FRAME_CYCLES));
    sw_delta   = swp_q.shadow >> swp_q.shift;
    sw_nf      = swp_q.negate ? ({1'b0, swp_q.shadow} - {1'b0, sw_delta})
                              : ({1'b0, swp_q.shadow} + {1'b0, sw_delta});
    left_prod  = 16'(lm_q * scale_q);
    right_prod = 16'(rm_q * scale_q);
  end

  // Register read mux with the fixed read masks.
  always_comb begin
    unique case (q_item_i.addr)
      A_NR52: rd_data = {power_q, 3'b111, von_q};
      A_NR51: rd_data = pan_q;
      A_NR50: rd_data = mvol_q;
      A_NR10: rd_data = {1'b1, swp_q.pace, swp_q.negate, swp_q.shift};
      A_NR11: rd_data = {duty_q[0], 6'h3F};
      A_NR21: rd_data = {duty_q[1], 6'h3F};
      A_NR12: rd_data = {env_q[0].init_vol, env_q[0].add, env_q[0].pace};
      A_NR22: rd_data = {env_q[1].init_vol, env_q[1].add, env_q[1].pace};
      A_NR42: rd_data = {env_q[2].init_vol, env_q[2].add, env_q[2].pace};
      A_NR14: rd_data = 8'hBF | {1'b0, lon_q[0], 6'd0};
      A_NR24: rd_data = 8'hBF | {1'b0, lon_q[1], 6'd0};
      A_NR34: rd_data = 8'hBF | {1'b0, lon_q[2], 6'd0};
      A_NR44: rd_data = 8'hBF | {1'b0, lon_q[3], 6'd0};
      A_NR30: rd_data = {dac_q[2], 7'h7F};
      A_NR32: rd_data = {1'b1, wlvl_q, 5'h1F};
      A_NR43: rd_data = {noise_q.shift, noise_q.narrow, noise_q.div};
      default: rd_data = 8'hFF;
    endcase
  end

  // Sequencer, unit state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rate_q   <= RATE_RESET;
      scale_q  <= SCALE_RESET;
      power_q  <= 1'b0;
      pan_q    <= '0;
      mvol_q   <= '0;
      acc_q    <= '0;
      fcc_q    <= '0;
      fstep_q  <= '0;
      von_q    <= '0;
      dac_q    <= '0;
      lon_q    <= '0;
      for (int v = 0; v < 4; v++) begin
        lload_q[v] <= '0;
        lleft_q[v] <= '0;
        pcd_q[v]   <= '0;
      end
      for (int v = 0; v < 3; v++) begin
        tp_q[v]  <= '0;
        env_q[v] <= '0;
      end
      for (int v = 0; v < 2; v++) begin
        duty_q[v] <= '0;
        dph_q[v]  <= '0;
      end
      swp_q   <= '0;
      wph_q   <= '0;
      wlvl_q  <= '0;
      for (int i = 0; i < WAVE_BYTES; i++) begin
        wave_q[i] <= '0;
      end
      noise_q <= '0;
      nsh_q   <= '0;
      cyc_q   <= '0;
      emit_q  <= 1'b0;
      lsum_q  <= '0;
      rsum_q  <= '0;
      lm_q    <= '0;
      rm_q    <= '0;
      out_valid_q     <= 1'b0;
      out_is_sample_q <= 1'b0;
      out_rdata_q     <= '0;
      out_left_q      <= '0;
      out_right_q     <= '0;
    end else begin
      // Configuration writes.
      if (cfg_i.we) begin
        unique case (cfg_i.index)
          CFG_SAMPLE_RATE: rate_q  <= cfg_i.data;
          default:         scale_q <= cfg_i.data[6:0];
        endcase
      end

      // A taken result frees the output register.
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i && q_ready_o) begin
            unique case (q_item_i.op)
              OP_TICK: begin
                // Count every running timer down by the tick length.
                cyc_q <= q_item_i.cyc;
                for (int v = 0; v < 4; v++) begin
                  if (von_q[v]) begin
                    pcd_q[v] <= pcd_q[v] - PCD_W'(q_item_i.cyc);
                  end
                end
                state_q <= ST_ADV;
              end
              OP_READ: begin
                out_valid_q     <= 1'b1;
                out_is_sample_q <= 1'b0;
                out_rdata_q     <= rd_data;
                out_left_q      <= '0;
                out_right_q     <= '0;
              end
              OP_WAVE: begin
                wave_q[q_item_i.addr[WAVE_AW-1:0]] <= q_item_i.data;
              end
              default: begin
                unique case (q_item_i.addr)
                  A_NR52: begin
                    if (q_item_i.data[7]) begin
                      power_q <= 1'b1;
                    end else begin
                      // Power off clears all voice state but the wave store.
                      power_q <= 1'b0;
                      von_q   <= '0;
                      dac_q   <= '0;
                      lon_q   <= '0;
                      for (int v = 0; v < 4; v++) begin
                        lload_q[v] <= '0;
                        lleft_q[v] <= '0;
                        pcd_q[v]   <= '0;
                      end
                      for (int v = 0; v < 3; v++) begin
                        tp_q[v]  <= '0;
                        env_q[v] <= '0;
                      end
                      for (int v = 0; v < 2; v++) begin
                        duty_q[v] <= '0;
                        dph_q[v]  <= '0;
                      end
                      swp_q   <= '0;
                      noise_q <= '0;
                      wph_q   <= '0;
                      wlvl_q  <= '0;
                      nsh_q   <= '0;
                    end
                  end
                  A_NR51: pan_q  <= q_item_i.data;
                  A_NR50: mvol_q <= q_item_i.data;
                  A_NR10: begin
                    swp_q.pace   <= q_item_i.data[6:4];
                    swp_q.negate <= q_item_i.data[3];
                    swp_q.shift  <= q_item_i.data[2:0];
                  end
                  A_NR11: begin
                    duty_q[0]  <= q_item_i.data[7:6];
                    lload_q[0] <= {2'b00, q_item_i.data[5:0]};
                  end
                  A_NR21: begin
                    duty_q[1]  <= q_item_i.data[7:6];
                    lload_q[1] <= {2'b00, q_item_i.data[5:0]};
                  end
                  A_NR12: begin
                    env_q[0].init_vol <= q_item_i.data[7:4];
                    env_q[0].add      <= q_item_i.data[3];
                    env_q[0].pace     <= q_item_i.data[2:0];
                    dac_q[0]          <= (q_item_i.data[7:3] != 5'd0);
                    if (q_item_i.data[7:3] == 5'd0) begin
                      von_q[0] <= 1'b0;
                    end
                  end
                  A_NR22: begin
                    env_q[1].init_vol <= q_item_i.data[7:4];
                    env_q[1].add      <= q_item_i.data[3];
                    env_q[1].pace     <= q_item_i.data[2:0];
                    dac_q[1]          <= (q_item_i.data[7:3] != 5'd0);
                    if (q_item_i.data[7:3] == 5'd0) begin
                      von_q[1] <= 1'b0;
                    end
                  end
                  A_NR42: begin
                    env_q[2].init_vol <= q_item_i.data[7:4];
                    env_q[2].add      <= q_item_i.data[3];
                    env_q[2].pace     <= q_item_i.data[2:0];
                    dac_q[3]          <= (q_item_i.data[7:3] != 5'd0);
                    if (q_item_i.data[7:3] == 5'd0) begin
                      von_q[3] <= 1'b0;
                    end
                  end
                  A_NR13: tp_q[0][7:0] <= q_item_i.data;
                  A_NR23: tp_q[1][7:0] <= q_item_i.data;
                  A_NR33: tp_q[2][7:0] <= q_item_i.data;
                  A_NR14, A_NR24: begin
                    tp_q[sq_idx] <= sq_tp_new;
                    lon_q[sq_idx] <= q_item_i.data[6];
                    if (q_item_i.data[7]) begin
                      // Square trigger.
                      pcd_q[sq_idx] <= sq_trig_per;
                      if (dac_q[sq_idx]) begin
                        von_q[sq_idx] <= 1'b1;
                      end
                      env_q[sq_idx].cur_vol <= env_q[sq_idx].init_vol;
                      env_q[sq_idx].count   <= env_q[sq_idx].pace;
                      if (lleft_q[sq_idx] == 9'd0) begin
                        lleft_q[sq_idx] <= 9'd64 - {1'b0, lload_q[sq_idx]};
                      end
                      if (!sq_v) begin
                        swp_q.shadow  <= sq_tp_new;
                        swp_q.count   <= (swp_q.pace == 3'd0) ? 4'd8 : {1'b0, swp_q.pace};
                        swp_q.enabled <= (swp_q.pace != 3'd0) || (swp_q.shift != 3'd0);
                      end
                    end
                  end
                  A_NR30: begin
                    dac_q[2] <= q_item_i.data[7];
                    if (!q_item_i.data[7]) begin
                      von_q[2] <= 1'b0;
                    end
                  end
                  A_NR31: lload_q[2] <= q_item_i.data;
                  A_NR32: wlvl_q <= q_item_i.data[6:5];
                  A_NR34: begin
                    tp_q[2]  <= wv_tp_new;
                    lon_q[2] <= q_item_i.data[6];
                    if (q_item_i.data[7]) begin
                      // Wave trigger.
                      pcd_q[2] <= PCD_W'({12'd2048 - {1'b0, wv_tp_new}, 1'b0});
                      wph_q    <= '0;
                      if (dac_q[2]) begin
                        von_q[2] <= 1'b1;
                      end
                      if (lleft_q[2] == 9'd0) begin
                        lleft_q[2] <= 9'd256 - {1'b0, lload_q[2]};
                      end
                    end
                  end
                  A_NR41: lload_q[3] <= {2'b00, q_item_i.data[5:0]};
                  A_NR43: begin
                    noise_q.div    <= q_item_i.data[2:0];
                    noise_q.narrow <= q_item_i.data[3];
                    noise_q.shift  <= q_item_i.data[7:4];
                  end
                  A_NR44: begin
                    lon_q[3] <= q_item_i.data[6];
                    if (q_item_i.data[7]) begin
                      // Noise trigger.
                      if (dac_q[3]) begin
                        von_q[3] <= 1'b1;
                      end
                      env_q[2].cur_vol <= env_q[2].init_vol;
                      env_q[2].count   <= env_q[2].pace;
                      if (lleft_q[3] == 9'd0) begin
                        lleft_q[3] <= 9'd64 - {1'b0, lload_q[3]};
                      end
                      nsh_q    <= 15'h7FFF;
                      pcd_q[3] <= nz_per;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            endcase
          end
        end

        ST_ADV: begin
          // One reload of every expired timer per cycle.
          for (int v = 0; v < 2; v++) begin
            if (due[v]) begin
              pcd_q[v] <= pcd_q[v] + sq_per[v];
              dph_q[v] <= dph_q[v] + 3'd1;
            end
          end
          if (due[2]) begin
            pcd_q[2] <= pcd_q[2] + wv_per;
            wph_q    <= wph_q + (WAVE_AW + 1)'(1);
          end
          if (due[3]) begin
            pcd_q[3] <= pcd_q[3] + nz_per;
            nsh_q    <= nz_next;
          end
          if (!adv_busy) begin
            state_q <= ST_MIX;
          end
        end

        ST_MIX: begin
          // Accumulate the sample clock and latch the panned sums.
          if (acc_sum >= ACC_W'(CPU_FREQ)) begin
            emit_q <= 1'b1;
            acc_q  <= (acc_sub >= ACC_W'(CPU_FREQ)) ? ACC_W'(CPU_FREQ - 1) : acc_sub;
          end else begin
            emit_q <= 1'b0;
            acc_q  <= acc_sum;
          end
          lsum_q  <= lsum;
          rsum_q  <= rsum;
          state_q <= ST_SCALE;
        end

        ST_SCALE: begin
          lm_q    <= 10'(lsum_q * ({1'b0, mvol_q[6:4]} + 4'd1));
          rm_q    <= 10'(rsum_q * ({1'b0, mvol_q[2:0]} + 4'd1));
          state_q <= ST_EMIT;
        end

        default: begin
          if (!emit_q || out_free) begin
            if (emit_q) begin
              out_valid_q     <= 1'b1;
              out_is_sample_q <= 1'b1;
              out_rdata_q     <= '0;
              out_left_q      <= signed'(left_prod);
              out_right_q     <= signed'(right_prod);
            end
            // Frame sequencer.
            if (power_q) begin
              if (fr_tick) begin
                fcc_q   <= fcc_sum - FCC_W'(FRAME_CYCLES);
                fstep_q <= fstep_q + 3'd1;
                if (!fstep_q[0]) begin
                  for (int v = 0; v < 4; v++) begin
                    if (lon_q[v] && (lleft_q[v] != 9'd0)) begin
                      lleft_q[v] <= lleft_q[v] - 9'd1;
                      if (lleft_q[v] == 9'd1) begin
                        von_q[v] <= 1'b0;
                      end
                    end
                  end
                end
                if (fstep_q[1:0] == 2'd2) begin
                  if (swp_q.count > 4'd1) begin
                    swp_q.count <= swp_q.count - 4'd1;
                  end else begin
                    swp_q.count <= (swp_q.pace == 3'd0) ? 4'd8 : {1'b0, swp_q.pace};
                    if (swp_q.enabled && (swp_q.pace != 3'd0)) begin
                      if (sw_nf[11]) begin
                        von_q[0]      <= 1'b0;
                        swp_q.enabled <= 1'b0;
                      end else begin
                        swp_q.shadow <= sw_nf[10:0];
                        tp_q[0]      <= sw_nf[10:0];
                      end
                    end
                  end
                end
                if (fstep_q == 3'd7) begin
                  for (int i = 0; i < 3; i++) begin
                    if (env_q[i].pace != 3'd0) begin
                      if (env_q[i].count > 3'd1) begin
                        env_q[i].count <= env_q[i].count - 3'd1;
                      end else begin
                        env_q[i].count <= env_q[i].pace;
                        if (env_q[i].add && (env_q[i].cur_vol != 4'd15)) begin
                          env_q[i].cur_vol <= env_q[i].cur_vol + 4'd1;
                        end else if (!env_q[i].add && (env_q[i].cur_vol != 4'd0)) begin
                          env_q[i].cur_vol <= env_q[i].cur_vol - 4'd1;
                        end
                      end
                    end
                  end
                end
              end else begin
                fcc_q <= fcc_sum;
              end
            end
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
